>>> src/cmpct_pkg.sv
// ----------------------------------------------------------------------------
// cmpct_pkg
// Shared widths, codes and control structs for the conditional match
// percentage block.
// ----------------------------------------------------------------------------
package cmpct_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int KIND_W       = 2;
  localparam int MODE_W       = 3;
  localparam int PCT_W        = 23;
  localparam int OUT_TDATA_W  = 24;
  localparam int FRAC_BITS    = 16;
  localparam int QUOT_HI_W    = PCT_W - FRAC_BITS;
  localparam int SCALE_W      = 7;
  localparam int DIGIT_W      = 4;
  localparam int DIGITS       = SAMPLE_W / DIGIT_W;
  localparam int REG_IDX_W    = 1;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_ADD   = 2'd0;
  localparam kind_t KIND_FLUSH = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_EQ = 3'd0;
  localparam mode_t MODE_NE = 3'd1;
  localparam mode_t MODE_LT = 3'd2;
  localparam mode_t MODE_LE = 3'd3;
  localparam mode_t MODE_GT = 3'd4;
  localparam mode_t MODE_GE = 3'd5;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_MODE   = 1'd0;
  localparam reg_idx_t REG_TARGET = 1'd1;

  typedef struct packed {
    logic done;
    logic match;
  } cmp_res_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_res_t;

endpackage

>>> src/cmpct_cmp_serial.sv
// ----------------------------------------------------------------------------
// cmpct_cmp_serial
// Digit-serial signed compare, one 4-bit digit per cycle, least significant
// digit first.
// ----------------------------------------------------------------------------
module cmpct_cmp_serial (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [cmpct_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [cmpct_pkg::SAMPLE_W-1:0] target,
  input  cmpct_pkg::mode_t                     mode,
  output cmpct_pkg::cmp_res_t                  res
);
  import cmpct_pkg::*;

  localparam int CNT_W = $clog2(DIGITS);

  logic [SAMPLE_W-1:0] s_sh_r;
  logic [SAMPLE_W-1:0] t_sh_r;
  mode_t               mode_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                eq_r;
  logic                lt_r;
  logic                done_r;
  logic                match_r;

  logic [DIGIT_W-1:0]  sd;
  logic [DIGIT_W-1:0]  td;
  logic                last;
  logic                dlt;
  logic                eq_nxt;
  logic                lt_nxt;
  logic                match_nxt;

  assign sd   = s_sh_r[DIGIT_W-1:0];
  assign td   = t_sh_r[DIGIT_W-1:0];
  assign last = (cnt_r == CNT_W'(DIGITS - 1));
  // top digit carries the sign
  assign dlt    = last ? ($signed(sd) < $signed(td)) : (sd < td);
  assign lt_nxt = (sd != td) ? dlt : lt_r;
  assign eq_nxt = eq_r & (sd == td);

  always_comb begin
    unique case (mode_r)
      MODE_EQ: match_nxt = eq_nxt;
      MODE_NE: match_nxt = ~eq_nxt;
      MODE_LT: match_nxt = lt_nxt;
      MODE_LE: match_nxt = lt_nxt | eq_nxt;
      MODE_GT: match_nxt = ~lt_nxt & ~eq_nxt;
      MODE_GE: match_nxt = ~lt_nxt;
      default: match_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_sh_r <= sample;
      t_sh_r <= target;
      mode_r <= mode;
      eq_r   <= 1'b1;
      lt_r   <= 1'b0;
    end else if (busy_r) begin
      s_sh_r  <= s_sh_r >> DIGIT_W;
      t_sh_r  <= t_sh_r >> DIGIT_W;
      eq_r    <= eq_nxt;
      lt_r    <= lt_nxt;
      match_r <= match_nxt;
    end
  end

  assign res.done  = done_r;
  assign res.match = match_r;

endmodule

>>> src/cmpct_div_serial.sv
// ----------------------------------------------------------------------------
// cmpct_div_serial
// Scale matched count by 100, then restoring division by the sample count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmpct_div_serial #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] matched,
  input  logic [COUNT_BITS-1:0] total,
  output cmpct_pkg::div_res_t   res
);
  import cmpct_pkg::*;

  localparam int PROD_W = COUNT_BITS + SCALE_W;
  localparam int CNT_W  = $clog2(PCT_W);

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_MUL  = 3'b010,
    DS_RUN  = 3'b100
  } dstate_t;

  dstate_t               state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [COUNT_BITS-1:0] m_r;
  logic [COUNT_BITS-1:0] n_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [PCT_W-1:0]      low_r;
  logic [PCT_W-1:0]      quot_r;

  logic [PROD_W-1:0]     prod;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  qbit;

  // times 100 as 64 + 32 + 4
  assign prod  = {1'b0, m_r, 6'b0} + {2'b0, m_r, 5'b0} + {5'b0, m_r, 2'b0};
  assign trial = {rem_r, low_r[PCT_W-1]};
  assign diff  = trial - {1'b0, n_r};
  assign qbit  = (trial >= {1'b0, n_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        DS_IDLE: begin
          if (start) state_r <= DS_MUL;
        end
        DS_MUL: begin
          cnt_r   <= '0;
          state_r <= DS_RUN;
        end
        DS_RUN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(PCT_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= DS_IDLE;
          end
        end
        default: state_r <= DS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state_r == DS_IDLE)) begin
      m_r <= matched;
      n_r <= total;
    end
    if (state_r == DS_MUL) begin
      // high part is below the divisor since the quotient fits PCT_W bits
      rem_r <= prod[PROD_W-1:QUOT_HI_W];
      low_r <= {prod[QUOT_HI_W-1:0], {FRAC_BITS{1'b0}}};
    end else if (state_r == DS_RUN) begin
      rem_r  <= qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      low_r  <= {low_r[PCT_W-2:0], 1'b0};
      quot_r <= {quot_r[PCT_W-2:0], qbit};
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

>>> src/conditional_match_percentage.sv
// ----------------------------------------------------------------------------
// conditional_match_percentage
// Counts samples that meet a configured relation against a target and
// reports the matched share as an unsigned Q7.16 percentage on flush.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------
//  in_     | in  | in_tvalid/tready    | tuser: kind, tdata: sample
//  out_    | out | out_tvalid/tready   | tdata: percent, tuser: empty_res
//  cfg_    | in  | cfg_valid/ready     | cfg_index, cfg_data
//
//  After a sample transfer the next input is taken only once the
//  digit-serial comparator has walked the 32-bit word 4 bits per cycle.
//  A flush with samples waits for the 23-step restoring divider; an
//  empty flush skips it and a clear item leaves the input ready.
//  Reset clears counters, registers and the output valid; no clearing pass.
//  A finished result holds in the output register while the input side
//  keeps taking items; a second flush waits only if that register is full.
// ----------------------------------------------------------------------------
module conditional_match_percentage #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cmpct_pkg::SAMPLE_W-1:0]      in_tdata,   // [31:0] sample
  input  cmpct_pkg::kind_t                    in_tuser,   // [1:0] kind
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cmpct_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [22:0] percent, [23] zero
  output logic                                out_tuser,  // [0] empty_res
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  cmpct_pkg::reg_idx_t                 cfg_index,
  input  logic [cmpct_pkg::SAMPLE_W-1:0]      cfg_data
);
  import cmpct_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_WAIT = 4'b1000
  } state_t;

  state_t                  state_r;
  mode_t                   mode_r;
  logic signed [SAMPLE_W-1:0] target_r;
  logic [COUNT_BITS-1:0]   matched_r;
  logic [COUNT_BITS-1:0]   sample_r;
  logic [PCT_W-1:0]        pend_pct_r;
  logic                    pend_empty_r;
  logic [PCT_W-1:0]        out_pct_r;
  logic                    out_empty_r;
  logic                    out_valid_r;

  logic                    in_xfer;
  logic                    cmp_start;
  logic                    div_start;
  logic                    out_load;
  cmp_res_t                cmp_res;
  div_res_t                div_res;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign cmp_start = in_xfer & (in_tuser == KIND_ADD);
  // empty flush skips the divider
  assign div_start = in_xfer & (in_tuser == KIND_FLUSH) & (sample_r != '0);
  assign out_load  = (state_r == ST_WAIT) & (~out_valid_r | out_tready);

  cmpct_cmp_serial u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmp_start),
    .sample (in_tdata),
    .target (target_r),
    .mode   (mode_r),
    .res    (cmp_res)
  );

  cmpct_div_serial #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .matched (matched_r),
    .total   (sample_r),
    .res     (div_res)
  );

  // Configuration: always ready; the user must write it only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_EQ;
      target_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
        REG_TARGET: target_r <= cfg_data;
      endcase
    end
  end

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      matched_r <= '0;
      sample_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            priority case (in_tuser)
              KIND_ADD:   state_r <= ST_CMP;
              KIND_FLUSH: begin
                // divider has captured the counters; clear them now
                state_r   <= (sample_r != '0) ? ST_DIV : ST_WAIT;
                matched_r <= '0;
                sample_r  <= '0;
              end
              KIND_CLEAR: begin
                matched_r <= '0;
                sample_r  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_CMP: begin
          if (cmp_res.done) begin
            sample_r <= sat_inc(sample_r);
            if (cmp_res.match) matched_r <= sat_inc(matched_r);
            state_r <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_res.done) state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Pending result: hold until the output register frees up.
  always_ff @(posedge clk) begin
    if (div_start || (in_xfer && (in_tuser == KIND_FLUSH))) begin
      pend_pct_r   <= '0;
      pend_empty_r <= 1'b1;
    end else if ((state_r == ST_DIV) && div_res.done) begin
      pend_pct_r   <= div_res.quot;
      pend_empty_r <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pct_r   <= pend_pct_r;
      out_empty_r <= pend_empty_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pct_r};
  assign out_tuser  = out_empty_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_match_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    matched_r <= sample_r)
    else $error("matched count exceeds sample count");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_cmp_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_res.done |-> (state_r == ST_CMP))
    else $error("comparator finished outside the compare state");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("empty result carries a nonzero percentage");

endmodule

>>> sim/match_share_checker.sv
// ----------------------------------------------------------------------------
// match_share_checker
// Watches the configuration, input and result channels of the conditional
// match percentage block. It keeps its own tallies and registers, predicts
// each flush result and compares it, field by field, with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module match_share_checker #(
  parameter int COUNT_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [cmpct_pkg::SAMPLE_W-1:0]     in_tdata,
  input  cmpct_pkg::kind_t                   in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [cmpct_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                               out_tuser,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  cmpct_pkg::reg_idx_t                cfg_index,
  input  logic [cmpct_pkg::SAMPLE_W-1:0]     cfg_data,
  output int unsigned                        fail_count,
  output int unsigned                        pending
);
  import cmpct_pkg::*;

  localparam logic [63:0] PERCENT_SCALE = 64'd100;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic             empty_res;
  } share_t;

  share_t                     share_due_q[$];
  mode_t                      rel_mode;
  logic signed [SAMPLE_W-1:0] target_q16;
  logic [COUNT_BITS-1:0]      match_tally;
  logic [COUNT_BITS-1:0]      sample_tally;

  function automatic logic meets_relation(input logic signed [SAMPLE_W-1:0] s,
                                          input logic signed [SAMPLE_W-1:0] t,
                                          input mode_t m);
    case (m)
      MODE_EQ: return s == t;
      MODE_NE: return s != t;
      MODE_LT: return s < t;
      MODE_LE: return s <= t;
      MODE_GT: return s > t;
      MODE_GE: return s >= t;
      default: return 1'b0;
    endcase
  endfunction

  // Hold at all ones instead of wrapping.
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  // Whole percent first, then 16 fraction bits from the remainder; truncate.
  function automatic logic [PCT_W-1:0] share_percent(input logic [COUNT_BITS-1:0] hits,
                                                     input logic [COUNT_BITS-1:0] total);
    logic [63:0] scaled;
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] frac;
    scaled = 64'(hits) * PERCENT_SCALE;
    whole  = scaled / 64'(total);
    rem    = scaled % 64'(total);
    frac   = (rem << FRAC_BITS) / 64'(total);
    return PCT_W'((whole << FRAC_BITS) + frac);
  endfunction

  always @(posedge clk) begin
    share_t got;
    share_t want;
    if (!rst_n) begin
      share_due_q.delete();
      rel_mode     = MODE_EQ;
      target_q16   = '0;
      match_tally  = '0;
      sample_tally = '0;
      fail_count   = 0;
    end else begin
      // Retire the oldest expectation before the input side can add one.
      if (out_tvalid && out_tready) begin
        got.percent   = out_tdata[PCT_W-1:0];
        got.empty_res = out_tuser;
        if (out_tdata[OUT_TDATA_W-1:PCT_W] != '0) begin
          $display("%0t: tdata pad mismatch, expected 0, actual %0d",
                   $time, out_tdata[OUT_TDATA_W-1:PCT_W]);
          fail_count++;
        end
        if (share_due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual percent %0d empty %0d",
                   $time, got.percent, got.empty_res);
          fail_count++;
        end else begin
          want = share_due_q.pop_front();
          if (got.percent != want.percent) begin
            $display("%0t: percent mismatch, expected %0d, actual %0d",
                     $time, want.percent, got.percent);
            fail_count++;
          end
          if (got.empty_res != want.empty_res) begin
            $display("%0t: empty_res mismatch, expected %0d, actual %0d",
                     $time, want.empty_res, got.empty_res);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   rel_mode   = cfg_data[MODE_W-1:0];
          REG_TARGET: target_q16 = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        case (in_tuser)
          KIND_ADD: begin
            if (meets_relation(in_tdata, target_q16, rel_mode))
              match_tally = bump(match_tally);
            sample_tally = bump(sample_tally);
          end
          KIND_FLUSH: begin
            want.empty_res = (sample_tally == '0);
            want.percent   = want.empty_res ? '0 : share_percent(match_tally, sample_tally);
            share_due_q.push_back(want);
            match_tally  = '0;
            sample_tally = '0;
          end
          KIND_CLEAR: begin
            match_tally  = '0;
            sample_tally = '0;
          end
          default: ;  // spare kind: no result, tallies untouched
        endcase
      end
    end
    pending <= share_due_q.size();
  end

endmodule

>>> sim/tb_conditional_match_percentage.sv
// ----------------------------------------------------------------------------
// tb_conditional_match_percentage
// Drives directed and random sample, flush and clear items into the block,
// across several compare modes and targets, with bursty input, a stalling
// receiver and two long output hold-offs. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_conditional_match_percentage;
  import cmpct_pkg::*;

  localparam int COUNT_BITS    = 32;
  localparam int TOTAL_ITEMS   = 1750;
  // Longest own latency is a flush through the serial divider.
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;

  // Codes outside the documented ranges, used to hit the ignore paths.
  localparam kind_t KIND_SPARE    = 2'd3;
  localparam mode_t MODE_SPARE_LO = 3'd6;
  localparam mode_t MODE_SPARE_HI = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata;
  kind_t                  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  reg_idx_t               cfg_index;
  logic [SAMPLE_W-1:0]    cfg_data;

  int unsigned            fail_count;
  int unsigned            pending;

  int                     stall_reqs;   // bumped by stimulus, served by receiver
  int                     burst_left;
  int                     items_sent;
  logic [SAMPLE_W-1:0]    cur_target;   // mirror of the target register

  conditional_match_percentage #(
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  match_share_checker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: pick a readiness style for a random stretch (always ready,
  // mostly ready, mostly stalled, periodic), and drop ready through a
  // LONG_HOLD countdown whenever the stimulus asks for a long hold-off.
  // --------------------------------------------------------------------------
  initial begin
    int style;
    int style_left;
    int hold_left;
    int stall_served;
    out_tready   = 1'b0;
    style        = 0;
    style_left   = 0;
    hold_left    = 0;
    stall_served = 0;
    forever begin
      @(posedge clk);
      if (stall_served != stall_reqs) begin
        stall_served++;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 160);
        end
        style_left--;
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (style_left % 5 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one item and hold it until the transfer. Between bursts of random
  // length, drop valid for a random gap (sometimes none, rarely a long one).
  task automatic offer(input kind_t k, input logic [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    if (k != KIND_SPARE) items_sent++;
  endtask

  // Leave valid high after the transfer; the caller drops it once the last
  // write of the group is done.
  task automatic write_reg(input reg_idx_t idx, input logic [SAMPLE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TARGET) cur_target = val;
  endtask

  // Drain: stop offering, wait until every expected result has come back,
  // then give the block time to finish a sample or clear that made none.
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic mode_t pick_mode();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    return mode_t'($urandom_range(MODE_EQ, MODE_GE));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // Bias samples toward the target and its neighbors so every relation
  // flips often; keep the extremes and fully random words in the mix.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1:    return cur_target;
      2:       return cur_target + 1;
      3:       return cur_target - 1;
      4:       return cur_target + $urandom_range(0, 16) - 8;
      5:       return 32'h7fff_ffff;
      6:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // One run: mostly short sample runs ending in a flush, sometimes empty or
  // long, sometimes broken by a clear or a spare-kind item, sometimes left
  // open so the tallies carry into the next run.
  task automatic sample_run();
    int len;
    int shape;
    shape = $urandom_range(0, 19);
    if (shape == 0)      len = 0;
    else if (shape == 1) len = $urandom_range(40, 120);
    else                 len = $urandom_range(1, 12);
    repeat (len) begin
      case ($urandom_range(0, 29))
        0:       offer(KIND_SPARE, $urandom());
        1:       offer(KIND_CLEAR, $urandom());
        default: offer(KIND_ADD, pick_sample());
      endcase
    end
    case ($urandom_range(0, 9))
      0:       offer(KIND_CLEAR, $urandom());
      1:       ;
      default: offer(KIND_FLUSH, $urandom());
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_ADD;
    cfg_valid  = 1'b0;
    cfg_index  = REG_MODE;
    cfg_data   = '0;
    stall_reqs = 0;
    burst_left = 0;
    items_sent = 0;
    cur_target = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Flush straight out of reset: empty result.
    offer(KIND_FLUSH, $urandom());
    // Reset mode (equal) against target zero: extremes and neighbors,
    // a spare-kind item that must change nothing, then a flush.
    offer(KIND_ADD, 32'h0000_0000);
    offer(KIND_ADD, 32'h7fff_ffff);
    offer(KIND_ADD, 32'h8000_0000);
    offer(KIND_ADD, 32'hffff_ffff);
    offer(KIND_ADD, 32'h0000_0000);
    offer(KIND_SPARE, 32'h0000_0000);
    offer(KIND_FLUSH, $urandom());
    // Clear in the middle of a run: the flush after it is empty.
    offer(KIND_ADD, 32'h0000_0000);
    offer(KIND_CLEAR, $urandom());
    offer(KIND_FLUSH, $urandom());
    settle();

    // Less-equal against the largest target: every sample matches, 100%.
    write_reg(REG_MODE, MODE_LE);
    write_reg(REG_TARGET, 32'h7fff_ffff);
    cfg_valid <= 1'b0;
    offer(KIND_ADD, 32'h7fff_ffff);
    offer(KIND_ADD, 32'h8000_0000);
    offer(KIND_ADD, 32'h1234_5678);
    offer(KIND_FLUSH, $urandom());
    settle();

    // Unused mode never matches, but the sample still counts: 0%, not empty.
    write_reg(REG_MODE, MODE_SPARE_LO);
    write_reg(REG_TARGET, 32'h8000_0000);
    cfg_valid <= 1'b0;
    offer(KIND_ADD, 32'h8000_0000);
    offer(KIND_FLUSH, $urandom());
    settle();

    // Greater than the smallest target: two of three, a fraction that truncates.
    write_reg(REG_MODE, MODE_GT);
    cfg_valid <= 1'b0;
    offer(KIND_ADD, 32'h8000_0000);
    offer(KIND_ADD, 32'h7fff_ffff);
    offer(KIND_ADD, 32'h0000_0001);
    offer(KIND_FLUSH, $urandom());

    // Random phases: reconfigure while idle, then a handful of runs.
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      settle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_MODE, pick_mode());
      if ($urandom_range(0, 3) != 0) write_reg(REG_TARGET, pick_target());
      cfg_valid <= 1'b0;
      // Hold the receiver off while flushes keep coming so the output
      // register fills and the input side backs up.
      if (phase == 1 || phase == 9) stall_reqs <= stall_reqs + 1;
      repeat ($urandom_range(4, 12)) sample_run();
      phase++;
    end
    // Close any open run so its tallies are checked too.
    offer(KIND_FLUSH, $urandom());
    settle();

    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
